@@ hw/rtl/mplb_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mplb_pkg: shared types and constants of the multi-policy load balancer
// Beat structs, function and policy codes, register indexes, helpers.
// ----------------------------------------------------------------------------
package mplb_pkg;

	localparam int PROVIDERS = 8;
	localparam int IDX_W     = (PROVIDERS > 1) ? $clog2(PROVIDERS) : 1;
	localparam int CNT_W     = $clog2(PROVIDERS + 1);
	localparam int TOT_W     = 48;

	localparam logic [31:0] LFSR_TAPS = 32'h8020_0003;
	localparam logic [52:0] SUM_MAX   = {1'b0, {52{1'b1}}};
	localparam logic [63:0] WEIGHT_NUM = 64'd1000;
	localparam logic [63:0] SCORE_NUM  = 64'd70;

	// func codes
	localparam logic [1:0] FUNC_SELECT = 2'd0;
	localparam logic [1:0] FUNC_REPORT = 2'd1;
	localparam logic [1:0] FUNC_SETCON = 2'd2;

	// strategy codes
	localparam logic [2:0] MODE_ROUND    = 3'd0;
	localparam logic [2:0] MODE_LEAST    = 3'd1;
	localparam logic [2:0] MODE_FASTEST  = 3'd2;
	localparam logic [2:0] MODE_WEIGHTED = 3'd3;
	localparam logic [2:0] MODE_ADAPTIVE = 3'd4;
	localparam logic [2:0] MODE_RANDOM   = 3'd5;

	// configuration register indexes
	localparam int CFG_IDX_W = 1;
	localparam logic [CFG_IDX_W-1:0] REG_STRATEGY = 1'd0;
	localparam logic [CFG_IDX_W-1:0] REG_SEED     = 1'd1;

	typedef struct packed {
		logic [1:0]  func;
		logic [7:0]  provider_mask;
		logic [2:0]  provider_index;
		logic [19:0] response_time;
		logic [15:0] connection_count;
	} item_t;

	typedef struct packed {
		logic [2:0] chosen_provider;
		logic       found;
	} result_t;

	function automatic logic [31:0] lfsr_next(input logic [31:0] w);
		logic [31:0] s;
		s = {1'b0, w[31:1]};
		if (w[0]) begin
			s = s ^ LFSR_TAPS;
		end
		return s;
	endfunction

	// floor(3 * max(0, 10 - conn) * 65536 / 10)
	function automatic logic [17:0] spare_term(input logic [15:0] conn);
		logic [17:0] v;
		case (conn)
			16'd0: v = 18'd196608;
			16'd1: v = 18'd176947;
			16'd2: v = 18'd157286;
			16'd3: v = 18'd137625;
			16'd4: v = 18'd117964;
			16'd5: v = 18'd98304;
			16'd6: v = 18'd78643;
			16'd7: v = 18'd58982;
			16'd8: v = 18'd39321;
			16'd9: v = 18'd19660;
			default: v = 18'd0;
		endcase
		return v;
	endfunction

endpackage

@@ hw/rtl/multi_policy_load_balancer.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// multi_policy_load_balancer: provider selection under six policies
// Per-provider statistics table with a sequencer around one shared divider.
// ----------------------------------------------------------------------------
// An item is taken when start is high and busy is low; for a report, set or
// non-empty select, busy then stays high until the item is finished. A select
// beat yields one result_valid pulse of one cycle that the receiver must take;
// report and set beats yield nothing. Report and set pass through the update
// state. Select with an empty mask answers straight from idle. Round robin,
// least connections, uniform random and the fallback policies scan the
// providers one per cycle. Fastest mean runs at most one 64-step restoring
// division per candidate, weighted random and adaptive up to two per
// candidate, plus a second scan and a two-step multiply for weighted random.
// Configuration writes are taken while idle.
// ----------------------------------------------------------------------------
module multi_policy_load_balancer (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              start,
	output logic                              busy,
	input  mplb_pkg::item_t                   item,
	output logic                              result_valid,
	output mplb_pkg::result_t                 result,
	input  logic                              cfg_valid,
	output logic                              cfg_ready,
	input  logic [mplb_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [31:0]                       cfg_data
);

	localparam int P   = mplb_pkg::PROVIDERS;
	localparam int IW  = mplb_pkg::IDX_W;
	localparam int CW  = mplb_pkg::CNT_W;
	localparam int TW  = mplb_pkg::TOT_W;

	typedef enum logic [3:0] {
		ST_IDLE, ST_UPD, ST_PREP, ST_SCAN, ST_DIV, ST_EVAL, ST_EVAL2,
		ST_MUL_LO, ST_MUL_HI, ST_DONE
	} state_t;

	typedef enum logic {DIV_MEAN, DIV_RECIP} div_kind_t;

	state_t state_q;

	// provider table
	logic        seen_q [P];
	logic [15:0] conn_q [P];
	logic [31:0] req_q  [P];
	logic [51:0] sum_q  [P];
	logic [TW-1:0] w_q  [P];

	logic [2:0]    mode_q;
	logic [CW-1:0] rot_q;
	logic [31:0]   lfsr_q;

	// latched beat
	logic [1:0]    func_q;
	logic [P-1:0]  mask_q;
	logic [19:0]   rt_q;
	logic [15:0]   cc_q;

	// scan control
	logic [IW-1:0] ptr_q;
	logic [CW-1:0] ord_q;
	logic [CW-1:0] tgt_q;
	logic [IW-1:0] best_q;
	logic          have_q;
	logic [63:0]   bestv_q;
	logic [31:0]   bestreq_q;
	logic          pass_q;
	logic [TW-1:0] total_q;
	logic [TW-1:0] run_q;
	logic [TW-1:0] r_q;
	logic [63:0]   prod_q;

	// shared divider
	logic [63:0]   dvd_q;
	logic [63:0]   dvs_q;
	logic [63:0]   rem_q;
	logic [63:0]   quo_q;
	logic [5:0]    dcnt_q;
	div_kind_t     kind_q;
	logic [63:0]   mean_q;
	logic [63:0]   recip_q;

	logic              strobe_q;
	mplb_pkg::result_t res_q;

	// combinational helpers
	logic [P-1:0]  mask_in;
	logic [CW-1:0] n_c;
	logic [IW-1:0] first_c;
	logic          cur;
	logic          at_end;
	logic [15:0]   conn_r;
	logic [31:0]   req_r;
	logic [51:0]   sum_r;
	logic [52:0]   sum_add;
	logic [64:0]   rem_sh;
	logic          rem_ge;
	logic [63:0]   rem_nx;
	logic [63:0]   quo_nx;
	logic [31:0]   lfsr_nx;
	logic [31+CW:0] draw;
	logic [CW-1:0] rot0;
	logic [63:0]   score;
	logic [TW-1:0] run_nx;
	logic          idx_ok;

	assign mask_in = P'(item.provider_mask);
	assign cur     = mask_q[ptr_q];
	assign at_end  = (ptr_q == IW'(P - 1));
	assign conn_r  = conn_q[ptr_q];
	assign req_r   = req_q[ptr_q];
	assign sum_r   = sum_q[ptr_q];
	assign sum_add = {1'b0, sum_r} + 53'(rt_q);
	assign rem_sh  = {rem_q, dvd_q[63]};
	assign rem_ge  = (rem_sh >= {1'b0, dvs_q});
	assign rem_nx  = rem_ge ? 64'(rem_sh - {1'b0, dvs_q}) : rem_sh[63:0];
	assign quo_nx  = {quo_q[62:0], rem_ge};
	assign lfsr_nx = mplb_pkg::lfsr_next(lfsr_q);
	assign draw    = (32+CW)'(lfsr_nx) * (32+CW)'(n_c);
	assign rot0    = (rot_q >= n_c) ? '0 : rot_q;
	assign score   = recip_q + 64'(mplb_pkg::spare_term(conn_r));
	assign run_nx  = run_q + w_q[ptr_q];
	assign idx_ok  = (32'(item.provider_index) < P);

	always_comb begin
		n_c     = '0;
		first_c = '0;
		for (int i = P - 1; i >= 0; i--) begin
			n_c = n_c + CW'(mask_q[i]);
			if (mask_q[i]) begin
				first_c = IW'(i);
			end
		end
	end

	assign busy         = (state_q != ST_IDLE);
	assign cfg_ready    = (state_q == ST_IDLE);
	assign result_valid = strobe_q;
	assign result       = res_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			mode_q   <= mplb_pkg::MODE_ROUND;
			rot_q    <= '0;
			lfsr_q   <= 32'd1;
			strobe_q <= 1'b0;
			for (int i = 0; i < P; i++) begin
				seen_q[i] <= 1'b0;
				conn_q[i] <= '0;
				req_q[i]  <= '0;
				sum_q[i]  <= '0;
			end
		end else begin
			// result pulse: finished select, or empty mask answered from idle
			strobe_q <= (state_q == ST_DONE) ||
				(state_q == ST_IDLE && start && item.func == mplb_pkg::FUNC_SELECT &&
				mask_in == '0);
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					mplb_pkg::REG_STRATEGY: mode_q <= cfg_data[2:0];
					mplb_pkg::REG_SEED: lfsr_q <= (cfg_data != '0) ? cfg_data : 32'd1;
					default: ;
				endcase
			end
			case (state_q)
				ST_IDLE: begin
					if (start) begin
						func_q <= item.func;
						mask_q <= mask_in;
						rt_q   <= item.response_time;
						cc_q   <= item.connection_count;
						ptr_q  <= IW'(item.provider_index);
						if (item.func == mplb_pkg::FUNC_SELECT) begin
							if (mask_in == '0) begin
								res_q <= '0;
							end else begin
								for (int i = 0; i < P; i++) begin
									if (mask_in[i]) begin
										seen_q[i] <= 1'b1;
									end
								end
								state_q <= ST_PREP;
							end
						end else if (idx_ok && (item.func == mplb_pkg::FUNC_REPORT ||
								item.func == mplb_pkg::FUNC_SETCON)) begin
							state_q <= ST_UPD;
						end
					end
				end
				ST_UPD: begin
					if (seen_q[ptr_q]) begin
						if (func_q == mplb_pkg::FUNC_REPORT) begin
							if (req_r != '1) begin
								req_q[ptr_q] <= req_r + 32'd1;
							end
							sum_q[ptr_q] <= (sum_add > mplb_pkg::SUM_MAX) ?
								mplb_pkg::SUM_MAX[51:0] : sum_add[51:0];
						end else begin
							conn_q[ptr_q] <= cc_q;
						end
					end
					state_q <= ST_IDLE;
				end
				ST_PREP: begin
					ptr_q   <= '0;
					ord_q   <= '0;
					have_q  <= 1'b0;
					pass_q  <= 1'b0;
					total_q <= '0;
					run_q   <= '0;
					best_q  <= first_c;
					case (mode_q)
						mplb_pkg::MODE_ROUND: begin
							tgt_q <= rot0;
							rot_q <= rot0 + CW'(1);
						end
						mplb_pkg::MODE_RANDOM: begin
							lfsr_q <= lfsr_nx;
							tgt_q  <= draw[32 +: CW];
						end
						mplb_pkg::MODE_WEIGHTED: begin
							lfsr_q <= lfsr_nx;
							tgt_q  <= '0;
						end
						default: tgt_q <= '0;
					endcase
					state_q <= ST_SCAN;
				end
				ST_SCAN: begin
					if (cur && (mode_q == mplb_pkg::MODE_FASTEST ||
							mode_q == mplb_pkg::MODE_ADAPTIVE ||
							(mode_q == mplb_pkg::MODE_WEIGHTED && !pass_q))) begin
						if (req_r == '0) begin
							mean_q  <= '0;
							state_q <= ST_EVAL;
						end else begin
							dvd_q   <= {sum_r, 12'd0};
							dvs_q   <= 64'(req_r);
							rem_q   <= '0;
							quo_q   <= '0;
							dcnt_q  <= '0;
							kind_q  <= DIV_MEAN;
							state_q <= ST_DIV;
						end
					end else begin
						if (cur) begin
							ord_q <= ord_q + CW'(1);
							case (mode_q)
								mplb_pkg::MODE_LEAST: begin
									if (!have_q || 64'(conn_r) < bestv_q) begin
										best_q  <= ptr_q;
										bestv_q <= 64'(conn_r);
										have_q  <= 1'b1;
									end
								end
								mplb_pkg::MODE_WEIGHTED: begin
									run_q <= run_nx;
									if (r_q <= run_nx) begin
										best_q <= ptr_q;
									end
								end
								default: begin
									if (ord_q == tgt_q) begin
										best_q <= ptr_q;
									end
								end
							endcase
						end
						if ((cur && mode_q == mplb_pkg::MODE_WEIGHTED && r_q <= run_nx) ||
								(cur && mode_q != mplb_pkg::MODE_LEAST &&
								mode_q != mplb_pkg::MODE_WEIGHTED && ord_q == tgt_q)) begin
							state_q <= ST_DONE;
						end else if (at_end) begin
							// weight pass over: draw the target before the pick pass
							state_q <= (mode_q == mplb_pkg::MODE_WEIGHTED && !pass_q) ?
								ST_MUL_LO : ST_DONE;
						end else begin
							ptr_q <= ptr_q + IW'(1);
						end
					end
				end
				ST_DIV: begin
					rem_q  <= rem_nx;
					quo_q  <= quo_nx;
					dvd_q  <= {dvd_q[62:0], 1'b0};
					dcnt_q <= dcnt_q + 6'd1;
					if (dcnt_q == 6'd63) begin
						if (kind_q == DIV_MEAN) begin
							mean_q  <= quo_nx;
							state_q <= ST_EVAL;
						end else begin
							recip_q <= quo_nx;
							state_q <= ST_EVAL2;
						end
					end
				end
				ST_EVAL: begin
					if (mode_q == mplb_pkg::MODE_FASTEST) begin
						if (mean_q != '0 && (!have_q || mean_q < bestv_q)) begin
							best_q  <= ptr_q;
							bestv_q <= mean_q;
							have_q  <= 1'b1;
						end
						if (at_end) begin
							state_q <= ST_DONE;
						end else begin
							ptr_q   <= ptr_q + IW'(1);
							state_q <= ST_SCAN;
						end
					end else if (mean_q == '0) begin
						recip_q <= ((mode_q == mplb_pkg::MODE_WEIGHTED) ?
							mplb_pkg::WEIGHT_NUM : mplb_pkg::SCORE_NUM) << 16;
						state_q <= ST_EVAL2;
					end else begin
						dvd_q   <= ((mode_q == mplb_pkg::MODE_WEIGHTED) ?
							mplb_pkg::WEIGHT_NUM : mplb_pkg::SCORE_NUM) << 32;
						dvs_q   <= mean_q;
						rem_q   <= '0;
						quo_q   <= '0;
						dcnt_q  <= '0;
						kind_q  <= DIV_RECIP;
						state_q <= ST_DIV;
					end
				end
				ST_EVAL2: begin
					if (mode_q == mplb_pkg::MODE_WEIGHTED) begin
						w_q[ptr_q] <= recip_q[TW-1:0];
						total_q    <= total_q + recip_q[TW-1:0];
					end else if (!have_q || score > bestv_q ||
							(score == bestv_q && req_r < bestreq_q)) begin
						best_q    <= ptr_q;
						bestv_q   <= score;
						bestreq_q <= req_r;
						have_q    <= 1'b1;
					end
					if (at_end) begin
						state_q <= (mode_q == mplb_pkg::MODE_WEIGHTED) ? ST_MUL_LO : ST_DONE;
					end else begin
						ptr_q   <= ptr_q + IW'(1);
						state_q <= ST_SCAN;
					end
				end
				ST_MUL_LO: begin
					// low partial product of total * draw
					prod_q  <= 64'(total_q[31:0]) * 64'(lfsr_q);
					state_q <= ST_MUL_HI;
				end
				ST_MUL_HI: begin
					r_q     <= TW'(48'(total_q[TW-1:32]) * 48'(lfsr_q)) + TW'(prod_q[63:32]);
					pass_q  <= 1'b1;
					ptr_q   <= '0;
					state_q <= ST_SCAN;
				end
				ST_DONE: begin
					res_q   <= {3'(best_q), 1'b1};
					state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// select handshake, divider and lfsr checks
	a_seen_marked: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_PREP) |-> (mask_q != '0))
		else $error("select sequence entered with empty mask");

	a_nothing_dropped: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_IDLE && start && item.func == mplb_pkg::FUNC_SELECT &&
		mask_in != '0) |=> (state_q == ST_PREP))
		else $error("select beat not latched");

	a_div_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DIV) |-> (dvs_q != '0))
		else $error("divider started with zero divisor");

	a_lfsr_live: assert property (@(posedge clk) disable iff (!arst_n)
		lfsr_q != '0)
		else $error("lfsr reached the all-zero lockup state");

	a_empty_result: assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid && !result.found) |-> (result.chosen_provider == '0))
		else $error("empty-mask result carries a provider");

endmodule

@@ tb/tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: self-checking bench for the multi-policy load balancer
// A directed table, then random select/report/set traffic under every policy,
// checked beat by beat against a behavioral model of the provider table.
// ----------------------------------------------------------------------------
module tb;

	localparam int IDLE_LIMIT = 20000;
	localparam logic [1:0] FUNC_UNUSED = 2'd3;

	typedef struct packed {
		mplb_pkg::item_t   it;
		bit                fixed;
		mplb_pkg::result_t want;
	} dir_row_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic start = 1'b0;
	logic busy;
	mplb_pkg::item_t item = '0;
	logic result_valid;
	mplb_pkg::result_t result;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [mplb_pkg::CFG_IDX_W-1:0] cfg_index = '0;
	logic [31:0] cfg_data = '0;

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	multi_policy_load_balancer uut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .item(item),
		.result_valid(result_valid), .result(result), .cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	// model of the provider table
	logic [2:0]  pol;
	logic [31:0] rng;
	logic        seen [mplb_pkg::PROVIDERS];
	logic [15:0] conns [mplb_pkg::PROVIDERS];
	logic [31:0] reqs [mplb_pkg::PROVIDERS];
	logic [51:0] rsum [mplb_pkg::PROVIDERS];
	logic [3:0]  rr_pos;

	mplb_pkg::result_t pending_picks[$];
	int errors = 0;
	int idle_cycles = 0;
	int send_gap_pct = 0;

	function automatic logic [63:0] mean_of(int p);
		logic [63:0] num;
		if (reqs[p] == 0) return 64'd0;
		num = {rsum[p], 12'd0};
		return num / reqs[p];
	endfunction

	function automatic logic [63:0] weight_of(int p);
		logic [63:0] m;
		m = mean_of(p);
		return (m != 0) ? (mplb_pkg::WEIGHT_NUM << 32) / m : (mplb_pkg::WEIGHT_NUM << 16);
	endfunction

	function automatic logic [63:0] score_of(int p);
		logic [63:0] m, s, spare;
		m = mean_of(p);
		s = (m != 0) ? (mplb_pkg::SCORE_NUM << 32) / m : (mplb_pkg::SCORE_NUM << 16);
		spare = (conns[p] < 10) ? 64'(10 - conns[p]) : 64'd0;
		return s + (spare * 3 * 65536) / 10;
	endfunction

	function automatic logic [31:0] rng_step(logic [31:0] w);
		return w[0] ? ({1'b0, w[31:1]} ^ mplb_pkg::LFSR_TAPS) : {1'b0, w[31:1]};
	endfunction

	// apply one accepted beat; returns 1 with a pick when a result is due
	function automatic bit apply_beat(mplb_pkg::item_t it, output mplb_pkg::result_t pick_out);
		int cand [mplb_pkg::PROVIDERS];
		int n, best;
		logic [63:0] bt, total, r, run, s, bs, x;
		bit have;
		n = 0;
		pick_out = '0;
		if (it.func == mplb_pkg::FUNC_SELECT) begin
			for (int i = 0; i < mplb_pkg::PROVIDERS; i++)
				if (it.provider_mask[i]) begin
					cand[n] = i;
					n++;
				end
			if (n == 0) return 1'b1;
			for (int i = 0; i < n; i++) seen[cand[i]] = 1'b1;
			best = cand[0];
			case (pol)
				mplb_pkg::MODE_ROUND: begin
					if (rr_pos >= n) rr_pos = '0;
					best = cand[rr_pos];
					rr_pos++;
				end
				mplb_pkg::MODE_LEAST: begin
					for (int i = 1; i < n; i++)
						if (conns[cand[i]] < conns[best]) best = cand[i];
				end
				mplb_pkg::MODE_FASTEST: begin
					have = 0;
					bt = 0;
					for (int i = 0; i < n; i++) begin
						s = mean_of(cand[i]);
						if (s > 0 && (!have || s < bt)) begin
							bt = s;
							best = cand[i];
							have = 1;
						end
					end
				end
				mplb_pkg::MODE_WEIGHTED: begin
					total = 0;
					run = 0;
					for (int i = 0; i < n; i++) total += weight_of(cand[i]);
					rng = rng_step(rng);
					r = (total >> 32) * rng + (((total & 64'hFFFF_FFFF) * rng) >> 32);
					for (int i = 0; i < n; i++) begin
						run += weight_of(cand[i]);
						if (r <= run) begin
							best = cand[i];
							break;
						end
					end
				end
				mplb_pkg::MODE_ADAPTIVE: begin
					bs = score_of(best);
					for (int i = 1; i < n; i++) begin
						s = score_of(cand[i]);
						if (s > bs || (s == bs && reqs[cand[i]] < reqs[best])) begin
							bs = s;
							best = cand[i];
						end
					end
				end
				mplb_pkg::MODE_RANDOM: begin
					rng = rng_step(rng);
					x = (64'(rng) * n) >> 32;
					best = cand[(x < n) ? x : 0];
				end
				default: ;
			endcase
			pick_out.chosen_provider = best[2:0];
			pick_out.found = 1'b1;
			return 1'b1;
		end
		if (!seen[it.provider_index]) return 1'b0;
		if (it.func == mplb_pkg::FUNC_REPORT) begin
			if (reqs[it.provider_index] != 32'hFFFF_FFFF) reqs[it.provider_index]++;
			rsum[it.provider_index] =
				(52'hF_FFFF_FFFF_FFFF - rsum[it.provider_index] < it.response_time)
				? 52'hF_FFFF_FFFF_FFFF : rsum[it.provider_index] + it.response_time;
		end else if (it.func == mplb_pkg::FUNC_SETCON) begin
			conns[it.provider_index] = it.connection_count;
		end
		return 1'b0;
	endfunction

	// result checker; the receiver cannot stall, so take every strobe
	always @(posedge clk) begin
		mplb_pkg::result_t exp_pick;
		if (result_valid) begin
			if (pending_picks.size() == 0) begin
				errors++;
				if (errors <= 10) $display("unexpected result %h", result);
			end else begin
				exp_pick = pending_picks.pop_front();
				if (result.chosen_provider !== exp_pick.chosen_provider ||
						result.found !== exp_pick.found) begin
					errors++;
					if (errors <= 10)
						$display("pick mismatch: exp %0d/%0b got %0d/%0b",
							exp_pick.chosen_provider, exp_pick.found,
							result.chosen_provider, result.found);
				end
			end
		end
	end

	// watchdog: cycles in which nothing moves
	always @(posedge clk) begin
		if ((start && !busy) || result_valid || (cfg_valid && cfg_ready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles > IDLE_LIMIT) begin
			$display("TB_ERROR");
			$finish;
		end
	end

	// start stays high after a beat until the next call or a drain drops it
	task automatic send_beat(mplb_pkg::item_t it, bit fixed = 1'b0,
			mplb_pkg::result_t want = '0);
		mplb_pkg::result_t pk;
		if ($urandom_range(99) < send_gap_pct) begin
			start <= 1'b0;
			@(posedge clk);
			while ($urandom_range(99) < send_gap_pct) @(posedge clk);
		end
		start <= 1'b1;
		item <= it;
		do @(posedge clk); while (busy);
		if (apply_beat(it, pk)) pending_picks = {pending_picks, (fixed ? want : pk)};
	endtask

	// settle: wait for all picks, then give report/set beats time to retire
	task automatic drain();
		start <= 1'b0;
		while (pending_picks.size() != 0) @(posedge clk);
		repeat (400) @(posedge clk);
	endtask

	task automatic write_reg(logic [mplb_pkg::CFG_IDX_W-1:0] idx, logic [31:0] val);
		drain();
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		if (idx == mplb_pkg::REG_STRATEGY) pol = val[2:0];
		else rng = (val != 0) ? val : 32'd1;
	endtask

	function automatic mplb_pkg::item_t mk(logic [1:0] f, logic [7:0] m, logic [2:0] ix,
			logic [19:0] rt, logic [15:0] cc);
		mplb_pkg::item_t it;
		it.func = f;
		it.provider_mask = m;
		it.provider_index = ix;
		it.response_time = rt;
		it.connection_count = cc;
		return it;
	endfunction

	function automatic dir_row_t row(mplb_pkg::item_t it, bit fixed,
			mplb_pkg::result_t want);
		dir_row_t d;
		d.it = it;
		d.fixed = fixed;
		d.want = want;
		return d;
	endfunction

	// mostly small response times, sometimes extremes
	function automatic mplb_pkg::item_t rand_item();
		logic [19:0] rt;
		logic [15:0] cc;
		logic [1:0] f;
		rt = ($urandom_range(9) == 0) ? 20'($urandom) : 20'($urandom_range(4000));
		cc = ($urandom_range(5) == 0) ? 16'($urandom) : 16'($urandom_range(14));
		f = ($urandom_range(29) == 0) ? FUNC_UNUSED : 2'($urandom_range(2));
		return mk(f, 8'($urandom), 3'($urandom), rt, cc);
	endfunction

	dir_row_t dir_tab [13];

	initial begin
		pol = mplb_pkg::MODE_ROUND;
		rng = 32'd1;
		rr_pos = '0;
		for (int i = 0; i < mplb_pkg::PROVIDERS; i++) begin
			seen[i] = 0; conns[i] = 0; reqs[i] = 0; rsum[i] = 0;
		end
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: empty mask, unseen updates, extremes, unknown func
		dir_tab = '{
			row(mk(mplb_pkg::FUNC_SELECT, 8'h00, 3'd0, 20'd0, 16'd0), 1'b1, '0),
			row(mk(mplb_pkg::FUNC_REPORT, 8'h00, 3'd7, 20'hFFFFF, 16'd0), 1'b0, '0),
			row(mk(mplb_pkg::FUNC_SETCON, 8'h00, 3'd5, 20'd0, 16'hFFFF), 1'b0, '0),
			row(mk(mplb_pkg::FUNC_SELECT, 8'hFF, 3'd0, 20'd0, 16'd0), 1'b1,
				'{chosen_provider: 3'd0, found: 1'b1}),
			row(mk(mplb_pkg::FUNC_SELECT, 8'hFF, 3'd0, 20'd0, 16'd0), 1'b0, '0),
			row(mk(mplb_pkg::FUNC_SELECT, 8'h80, 3'd0, 20'd0, 16'd0), 1'b1,
				'{chosen_provider: 3'd7, found: 1'b1}),
			row(mk(mplb_pkg::FUNC_REPORT, 8'h00, 3'd7, 20'hFFFFF, 16'd0), 1'b0, '0),
			row(mk(mplb_pkg::FUNC_REPORT, 8'h00, 3'd0, 20'd0, 16'd0), 1'b0, '0),
			row(mk(mplb_pkg::FUNC_REPORT, 8'h00, 3'd1, 20'd16, 16'd0), 1'b0, '0),
			row(mk(mplb_pkg::FUNC_SETCON, 8'h00, 3'd7, 20'd0, 16'hFFFF), 1'b0, '0),
			row(mk(mplb_pkg::FUNC_SETCON, 8'h00, 3'd2, 20'd0, 16'd0), 1'b0, '0),
			row(mk(FUNC_UNUSED, 8'hFF, 3'd3, 20'hFFFFF, 16'hFFFF), 1'b0, '0),
			row(mk(mplb_pkg::FUNC_SELECT, 8'h01, 3'd0, 20'd0, 16'd0), 1'b1,
				'{chosen_provider: 3'd0, found: 1'b1})
		};
		send_gap_pct = 33;
		foreach (dir_tab[i]) send_beat(dir_tab[i].it, dir_tab[i].fixed, dir_tab[i].want);
		for (int m = 0; m < 8; m++) begin
			write_reg(mplb_pkg::REG_STRATEGY, m);
			send_beat(mk(mplb_pkg::FUNC_SELECT, 8'hFF, 3'd0, 20'd0, 16'd0));
			send_beat(mk(mplb_pkg::FUNC_SELECT, 8'h83, 3'd0, 20'd0, 16'd0));
		end
		write_reg(mplb_pkg::REG_SEED, 32'd0);
		write_reg(mplb_pkg::REG_SEED, 32'hFFFF_FFFF);

		// random: three idling phases, each across several settings
		for (int ph = 0; ph < 3; ph++) begin
			send_gap_pct = (ph == 0) ? 33 : (ph == 1) ? 86 : 0;
			for (int k = 0; k < 8; k++) begin
				write_reg(mplb_pkg::REG_STRATEGY, (k < 6) ? k : $urandom_range(7));
				if (k % 3 == 0) write_reg(mplb_pkg::REG_SEED, $urandom);
				repeat (25) send_beat(rand_item());
				if (k == 4) drain();
			end
		end
		drain();
		if (errors == 0 && pending_picks.size() == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

endmodule
